@@ rtl/core/tsb_pkg.sv @@
// Shared types and constants for the text screen buffer.
`timescale 1ns / 1ps

package tsb_pkg;

   // Command codes
   localparam logic [2:0] CMD_CLEAR_ALL  = 3'd0;
   localparam logic [2:0] CMD_PUT_CHAR   = 3'd1;
   localparam logic [2:0] CMD_NEWLINE    = 3'd2;
   localparam logic [2:0] CMD_BACKSPACE  = 3'd3;
   localparam logic [2:0] CMD_CLEAR_LINE = 3'd4;
   localparam logic [2:0] CMD_READ_CELL  = 3'd5;

   // Character codes
   localparam logic [7:0] SPACE_CODE   = 8'h20;
   localparam logic [7:0] NEWLINE_CODE = 8'h0A;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_FILL,
      ST_SCROLL,
      ST_SCROLL_TAIL,
      ST_READ_WAIT,
      ST_DONE
   } state_type;

   // Cell walker control, sized for the largest screen
   typedef struct packed {
      logic       start;
      logic       step;
      logic [4:0] first_row;
      logic [4:0] last_row;
   } sweep_ctl_type;

   // Cell walker position
   typedef struct packed {
      logic [4:0] row;
      logic [6:0] col;
      logic       last;
   } sweep_stat_type;

endpackage

@@ rtl/core/tsb_ram.sv @@
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps

module tsb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 3072
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/tsb_sweep.sv @@
// Cell walker: steps row by row, column by column over a range of screen rows.
`timescale 1ns / 1ps

module tsb_sweep #(
   parameter int COLUMNS   = 80,
   parameter int TEXT_ROWS = 24
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tsb_pkg::sweep_ctl_type  ctl,
   output tsb_pkg::sweep_stat_type stat
);
   import tsb_pkg::*;

   localparam int CW = $clog2(COLUMNS);
   localparam int RW = $clog2(TEXT_ROWS);
   localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);
   localparam logic [RW-1:0] ROW_LAST = RW'(TEXT_ROWS - 1);

   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] last_row_ff, last_row_in;

   // Next position: load on start, else advance with column wrap
   always_comb begin
      row_in      = row_ff;
      col_in      = col_ff;
      last_row_in = last_row_ff;
      if (ctl.start) begin
         row_in      = ctl.first_row[RW-1:0];
         col_in      = '0;
         last_row_in = ctl.last_row[RW-1:0];
      end else if (ctl.step) begin
         if (col_ff == COL_LAST) begin
            col_in = '0;
            row_in = row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   // Reset leaves the walker set up for the power-on clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= '0;
         col_ff      <= '0;
         last_row_ff <= ROW_LAST;
      end else begin
         row_ff      <= row_in;
         col_ff      <= col_in;
         last_row_ff <= last_row_in;
      end
   end

   assign stat.row  = 5'(row_ff);
   assign stat.col  = 7'(col_ff);
   assign stat.last = (row_ff == last_row_ff) && (col_ff == COL_LAST);

endmodule

@@ rtl/core/text_screen_buffer_core.sv @@
// Text screen buffer top level: command sequencer, cursor and screen store.
// Each request beat carries one command and yields exactly one response beat holding the
// cursor after the command and, for a read, the addressed character. Put char,
// newline off the last row, backspace and unused codes go straight to ST_DONE;
// read cell passes through ST_READ_WAIT first (unless the addressed cell lies off the
// screen); clear line and clear all fill one row or the whole screen through the cell
// walker; a newline on the last row scrolls every row up and blanks the bottom row.
// These operations are paced by the single write port of the screen RAM, which a cell
// walker drives one cell per cycle. After reset a clearing pass fills the screen with
// spaces, during which req_stall is high. A new request is taken while a finished
// response still waits in the output register.
`timescale 1ns / 1ps

module text_screen_buffer_core #(
   parameter int COLUMNS   = 80,
   parameter int TEXT_ROWS = 24
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_cmd,
   input  logic [7:0] req_char_code,
   input  logic [6:0] req_chars_in_line,
   input  logic [4:0] req_read_row,
   input  logic [6:0] req_read_col,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_cell_char,
   output logic [4:0] rsp_cursor_row,
   output logic [6:0] rsp_cursor_col
);
   import tsb_pkg::*;

   localparam int CW    = $clog2(COLUMNS);
   localparam int RW    = $clog2(TEXT_ROWS);
   localparam int AW    = RW + CW;
   localparam int DEPTH = TEXT_ROWS * (2 ** CW);
   localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);
   localparam logic [RW-1:0] ROW_LAST = RW'(TEXT_ROWS - 1);

   state_type      state_ff, state_in;
   logic [RW-1:0]  cur_row_ff, cur_row_in;
   logic [CW-1:0]  cur_col_ff, cur_col_in;
   logic [7:0]     cell_ff, cell_in;
   logic           pend_ff, pend_in;
   logic [AW-1:0]  pend_addr_ff, pend_addr_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [7:0]     rsp_cell_ff, rsp_cell_in;
   logic [RW-1:0]  rsp_row_ff, rsp_row_in;
   logic [CW-1:0]  rsp_col_ff, rsp_col_in;

   logic           accept;
   logic           wr_en;
   logic [AW-1:0]  wr_addr;
   logic [7:0]     wr_data;
   logic [AW-1:0]  rd_addr;
   logic [7:0]     rd_data;
   logic [7:0]     scroll_data;
   logic           read_in_range;
   logic [RW-1:0]  bs_row;
   logic [CW-1:0]  bs_col;
   logic [RW-1:0]  sw_row;
   logic [CW-1:0]  sw_col;

   sweep_ctl_type  sw_ctl;
   sweep_stat_type sw_stat;

   // Screen store, addressed as {row, column}
   tsb_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Shared cell walker for fills and scrolls
   tsb_sweep #(
      .COLUMNS   (COLUMNS),
      .TEXT_ROWS (TEXT_ROWS)
   ) u_sweep (
      .clock (clock),
      .reset (reset),
      .ctl   (sw_ctl),
      .stat  (sw_stat)
   );

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign sw_row    = sw_stat.row[RW-1:0];
   assign sw_col    = sw_stat.col[CW-1:0];

   // Newline markers turn into spaces as rows move up
   assign scroll_data = (rd_data == NEWLINE_CODE) ? SPACE_CODE : rd_data;

   assign read_in_range = (6'(req_read_row) < 6'(TEXT_ROWS)) &&
                          (8'(req_read_col) < 8'(COLUMNS));

   // Cell before the cursor in row-major order
   always_comb begin
      if (cur_col_ff == '0) begin
         bs_row = cur_row_ff - RW'(1);
         bs_col = COL_LAST;
      end else begin
         bs_row = cur_row_ff;
         bs_col = cur_col_ff - CW'(1);
      end
   end

   // Sequencer: next state, RAM ports, walker control and cursor update
   always_comb begin
      state_in     = state_ff;
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      cell_in      = cell_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_cell_in  = rsp_cell_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      wr_en        = 1'b0;
      wr_addr      = {cur_row_ff, cur_col_ff};
      wr_data      = SPACE_CODE;
      rd_addr      = {req_read_row[RW-1:0], req_read_col[CW-1:0]};
      sw_ctl       = '0;

      case (state_ff)
         ST_INIT: begin
            wr_en       = 1'b1;
            wr_addr     = {sw_row, sw_col};
            sw_ctl.step = 1'b1;
            if (sw_stat.last) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (accept) begin
               cell_in  = '0;
               state_in = ST_DONE;
               case (req_cmd)
                  CMD_CLEAR_ALL: begin
                     cur_row_in       = '0;
                     cur_col_in       = '0;
                     sw_ctl.start     = 1'b1;
                     sw_ctl.first_row = '0;
                     sw_ctl.last_row  = 5'(ROW_LAST);
                     state_in         = ST_FILL;
                  end
                  CMD_PUT_CHAR: begin
                     wr_en   = 1'b1;
                     wr_data = req_char_code;
                     cur_col_in = (cur_col_ff == COL_LAST) ? '0 : cur_col_ff + CW'(1);
                  end
                  CMD_NEWLINE: begin
                     if (cur_col_ff != COL_LAST) begin
                        wr_en   = 1'b1;
                        wr_addr = {cur_row_ff, cur_col_ff + CW'(1)};
                        wr_data = NEWLINE_CODE;
                     end
                     cur_col_in = '0;
                     if (cur_row_ff != ROW_LAST) begin
                        cur_row_in = cur_row_ff + RW'(1);
                     end else begin
                        sw_ctl.start     = 1'b1;
                        sw_ctl.first_row = 5'd1;
                        sw_ctl.last_row  = 5'(ROW_LAST);
                        pend_in          = 1'b0;
                        state_in         = ST_SCROLL;
                     end
                  end
                  CMD_BACKSPACE: begin
                     if ((req_chars_in_line != '0) &&
                         !((cur_row_ff == '0) && (cur_col_ff == '0))) begin
                        cur_row_in = bs_row;
                        cur_col_in = bs_col;
                        wr_en      = 1'b1;
                        wr_addr    = {bs_row, bs_col};
                     end
                  end
                  CMD_CLEAR_LINE: begin
                     sw_ctl.start     = 1'b1;
                     sw_ctl.first_row = 5'(cur_row_ff);
                     sw_ctl.last_row  = 5'(cur_row_ff);
                     state_in         = ST_FILL;
                  end
                  CMD_READ_CELL: begin
                     if (read_in_range) begin
                        state_in = ST_READ_WAIT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_FILL: begin
            wr_en       = 1'b1;
            wr_addr     = {sw_row, sw_col};
            sw_ctl.step = 1'b1;
            if (sw_stat.last) begin
               state_in = ST_DONE;
            end
         end

         // Read one row down, write it in the next cycle one row up
         ST_SCROLL: begin
            rd_addr = {sw_row, sw_col};
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = pend_addr_ff;
               wr_data = scroll_data;
            end
            pend_in      = 1'b1;
            pend_addr_in = {sw_row - RW'(1), sw_col};
            sw_ctl.step  = 1'b1;
            if (sw_stat.last) begin
               state_in = ST_SCROLL_TAIL;
            end
         end

         // Last moved cell, then blank the bottom row
         ST_SCROLL_TAIL: begin
            wr_en            = 1'b1;
            wr_addr          = pend_addr_ff;
            wr_data          = scroll_data;
            pend_in          = 1'b0;
            sw_ctl.start     = 1'b1;
            sw_ctl.first_row = 5'(ROW_LAST);
            sw_ctl.last_row  = 5'(ROW_LAST);
            state_in         = ST_FILL;
         end

         ST_READ_WAIT: begin
            cell_in  = rd_data;
            state_in = ST_DONE;
         end

         // Hand the beat to the output register once it is free
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_cell_in  = cell_ff;
               rsp_row_in   = cur_row_ff;
               rsp_col_in   = cur_col_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control and cursor registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cell_ff      <= cell_in;
      pend_addr_ff <= pend_addr_in;
      rsp_cell_ff  <= rsp_cell_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_char  = rsp_cell_ff;
   assign rsp_cursor_row = 5'(rsp_row_ff);
   assign rsp_cursor_col = 7'(rsp_col_ff);

   // Cursor stays on the screen
   a_cursor_in_range: assert property (@(posedge clock) disable iff (reset)
      (int'(cur_row_ff) < TEXT_ROWS) && (int'(cur_col_ff) < COLUMNS))
      else $error("cursor off screen");

   // Cursor moves only on an accepted beat
   a_cursor_hold: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(cur_row_ff) && $stable(cur_col_ff))
      else $error("cursor moved without a command");

   // Idle writes come only from an accepted command
   a_idle_write: assert property (@(posedge clock) disable iff (reset)
      (wr_en && state_ff == ST_IDLE) |-> accept)
      else $error("write in idle without a command");

   // Scroll never reads the top row
   a_scroll_rows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCROLL) |-> (sw_row != '0))
      else $error("scroll walker on top row");

   // Output register is only loaded when free or draining
   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_valid_ff && rsp_stall) |=> (state_ff == ST_DONE))
      else $error("response overwritten while stalled");

endmodule
